// ===== rtl/core/swt_pkg.sv =====
// Shared types and constants for the script word tokenizer.
package swt_pkg;

    localparam int MaxResults = 4;
    localparam int CountW     = $clog2(MaxResults + 1);
    localparam int IdxW       = $clog2(MaxResults);

    localparam logic [2:0] KIND_CHAR = 3'd0;
    localparam logic [2:0] KIND_END  = 3'd1;
    localparam logic [2:0] KIND_DROP = 3'd2;
    localparam logic [2:0] KIND_OK   = 3'd3;
    localparam logic [2:0] KIND_ERR  = 3'd4;

    localparam logic [3:0] REG_MAP_LINE_BREAKS  = 4'd0;
    localparam logic [3:0] REG_ARITH_DELIMITERS = 4'd1;

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] ch;
    } result_t;

    typedef struct packed {
        result_t [MaxResults-1:0] res;
        logic [CountW-1:0]        count;
    } res_list_t;

    typedef struct packed {
        logic in_quote;
        logic escape_pending;
        logic word_open;
    } lex_state_t;

    typedef struct packed {
        logic map_line_breaks;
        logic arith_delimiters;
    } lex_cfg_t;

endpackage

// ===== rtl/core/swt_decode.sv =====
// Per-byte lexer decode: result list and next lexer state for one word.
module swt_decode
    import swt_pkg::*;
(
    input  logic [7:0] char_in,
    input  logic       end_of_script,
    input  lex_state_t state,
    input  lex_cfg_t   cfg,
    output res_list_t  list,
    output lex_state_t state_next
);

    logic [7:0]        c;
    logic              punct;
    logic [CountW-1:0] cnt;
    lex_state_t        st;

    always_comb begin
        c = (cfg.map_line_breaks && (char_in == CH_CR || char_in == CH_LF)) ? CH_SPACE
                                                                            : char_in;
        unique case (c)
            CH_SEMI, CH_COMMA, CH_EQ, CH_LBRK, CH_RBRK, CH_LT, CH_GT,
            CH_LPAR, CH_RPAR, CH_LBRACE, CH_RBRACE: punct = 1'b1;
            CH_PLUS, CH_MINUS, CH_STAR:             punct = cfg.arith_delimiters;
            default:                                punct = 1'b0;
        endcase
    end

    always_comb begin
        list = '0;
        cnt  = '0;
        st   = state;

        if (state.in_quote) begin
            if (state.escape_pending) begin
                st.escape_pending = 1'b0;
                if (c == CH_BSLASH || c == CH_QUOTE) begin
                    list.res[cnt[IdxW-1:0]] = '{kind: KIND_CHAR, ch: c};
                    cnt = cnt + 1'b1;
                end else begin
                    list.res[cnt[IdxW-1:0]] = '{kind: KIND_CHAR, ch: CH_BSLASH};
                    cnt = cnt + 1'b1;
                    list.res[cnt[IdxW-1:0]] = '{kind: KIND_CHAR, ch: c};
                    cnt = cnt + 1'b1;
                end
            end else if (c == CH_BSLASH) begin
                st.escape_pending = 1'b1;
            end else if (c == CH_QUOTE) begin
                list.res[cnt[IdxW-1:0]] = '{kind: KIND_END, ch: 8'h00};
                cnt = cnt + 1'b1;
                st.in_quote = 1'b0;
            end else begin
                list.res[cnt[IdxW-1:0]] = '{kind: KIND_CHAR, ch: c};
                cnt = cnt + 1'b1;
            end
        end else if (c == CH_SPACE) begin
            if (state.word_open) begin
                list.res[cnt[IdxW-1:0]] = '{kind: KIND_END, ch: 8'h00};
                cnt = cnt + 1'b1;
            end
            st.word_open = 1'b0;
        end else if (c == CH_QUOTE) begin
            // drop the partial word, then open the quoted token
            if (state.word_open) begin
                list.res[cnt[IdxW-1:0]] = '{kind: KIND_DROP, ch: 8'h00};
                cnt = cnt + 1'b1;
            end
            st.word_open      = 1'b0;
            st.in_quote       = 1'b1;
            st.escape_pending = 1'b0;
        end else if (punct) begin
            if (state.word_open) begin
                list.res[cnt[IdxW-1:0]] = '{kind: KIND_END, ch: 8'h00};
                cnt = cnt + 1'b1;
            end
            st.word_open = 1'b0;
            list.res[cnt[IdxW-1:0]] = '{kind: KIND_CHAR, ch: c};
            cnt = cnt + 1'b1;
            list.res[cnt[IdxW-1:0]] = '{kind: KIND_END, ch: 8'h00};
            cnt = cnt + 1'b1;
        end else begin
            list.res[cnt[IdxW-1:0]] = '{kind: KIND_CHAR, ch: c};
            cnt = cnt + 1'b1;
            st.word_open = 1'b1;
        end

        if (end_of_script) begin
            if (st.in_quote) begin
                list.res[cnt[IdxW-1:0]] = '{kind: KIND_ERR, ch: 8'h00};
                cnt = cnt + 1'b1;
            end else begin
                if (st.word_open) begin
                    list.res[cnt[IdxW-1:0]] = '{kind: KIND_END, ch: 8'h00};
                    cnt = cnt + 1'b1;
                end
                list.res[cnt[IdxW-1:0]] = '{kind: KIND_OK, ch: 8'h00};
                cnt = cnt + 1'b1;
            end
            st = '0;
        end

        list.count = cnt;
        state_next = st;
    end

endmodule

// ===== rtl/core/script_word_tokenizer_top.sv =====
// Streaming script tokenizer: top level with state, config and output sequencing.
//
// Input channel (s_*): one script byte per word, s_end_of_script on the final
// byte. Each byte is decoded in the cycle it is accepted into a list of zero
// to four results, which are then sent one per cycle on the m_* channel;
// m_run_last marks the final result of a byte. Bytes with no result (a space
// with no open word, a backslash in a quote) leave no trace on the output.
// The decoded list is registered before its first result is shown. A byte that
// gives one result sustains one byte per cycle while m_ready is high; a byte
// with n results holds the output until all n leave the single result port.
// A two-deep result list buffer (current plus one pending) lets the next byte
// be taken while a result still waits: s_ready drops only when the pending
// list is full. When m_ready is low the current result holds.
// Config writes (cfg_*) are always accepted; index 0 maps CR/LF to space,
// index 1 adds + - * as delimiters, other indexes are ignored.
// Reset (aresetn low, synchronous) empties the buffers, clears the lexer
// state and restores map_line_breaks = 1, arith_delimiters = 0.
module script_word_tokenizer_top
    import swt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    input  logic       s_end_of_script,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_kind,
    output logic [7:0] m_char_out,
    output logic       m_run_last,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_index,
    input  logic [7:0] cfg_data
);

    lex_cfg_t   cfg_reg, cfg_next;
    lex_state_t state_reg, state_next, dec_state;
    res_list_t  dec_list;

    res_list_t         cur_reg, cur_next;
    res_list_t         pend_reg, pend_next;
    logic              cur_valid_reg, cur_valid_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [IdxW-1:0]   idx_reg, idx_next;

    logic s_accept;
    logic dec_has;
    logic is_last;
    logic cur_done;
    logic cur_free;

    swt_decode u_decode (
        .char_in       (s_char_in),
        .end_of_script (s_end_of_script),
        .state         (state_reg),
        .cfg           (cfg_reg),
        .list          (dec_list),
        .state_next    (dec_state)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = !pend_valid_reg;
    assign s_accept  = s_valid && s_ready;
    assign dec_has   = (dec_list.count != '0);

    assign is_last    = ({1'b0, idx_reg} == (cur_reg.count - 1'b1));
    assign m_valid    = cur_valid_reg;
    assign m_kind     = cur_reg.res[idx_reg].kind;
    assign m_char_out = cur_reg.res[idx_reg].ch;
    assign m_run_last = is_last;

    assign cur_done = cur_valid_reg && m_ready && is_last;
    assign cur_free = !cur_valid_reg || cur_done;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_MAP_LINE_BREAKS:  cfg_next.map_line_breaks  = cfg_data[0];
                REG_ARITH_DELIMITERS: cfg_next.arith_delimiters = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next      = s_accept ? dec_state : state_reg;
        cur_next        = cur_reg;
        pend_next       = pend_reg;
        cur_valid_next  = cur_valid_reg;
        pend_valid_next = pend_valid_reg;
        idx_next        = idx_reg;

        // advance within the current list
        if (cur_valid_reg && m_ready && !is_last) begin
            idx_next = idx_reg + 1'b1;
        end

        if (cur_free) begin
            idx_next = '0;
            if (pend_valid_reg) begin
                cur_next        = pend_reg;
                cur_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
            end else if (s_accept && dec_has) begin
                cur_next       = dec_list;
                cur_valid_next = 1'b1;
            end else begin
                cur_valid_next = 1'b0;
            end
        end else if (s_accept && dec_has) begin
            // hold the new list until the current one drains
            pend_next       = dec_list;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg        <= '{map_line_breaks: 1'b1, arith_delimiters: 1'b0};
            state_reg      <= '0;
            cur_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end else begin
            cfg_reg        <= cfg_next;
            state_reg      <= state_next;
            cur_valid_reg  <= cur_valid_next;
            pend_valid_reg <= pend_valid_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        pend_reg <= pend_next;
    end

endmodule

// ===== dv/script_word_tokenizer_top_tb.sv =====
// Self-checking testbench for the script word tokenizer: directed rows, random scripts.
module script_word_tokenizer_top_tb
    import swt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [2:0]  N_PRED = 3'd7;
    localparam logic [10:0] NIL    = 11'd0;
    localparam logic [10:0] R_END  = {KIND_END,  8'h00};
    localparam logic [10:0] R_DROP = {KIND_DROP, 8'h00};
    localparam logic [10:0] R_OK   = {KIND_OK,   8'h00};
    localparam logic [10:0] R_ERR  = {KIND_ERR,  8'h00};

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] ch;
        logic       last;
    } tok_t;

    // one script byte; n is the typed result count, or N_PRED to use the predictor
    typedef struct packed {
        logic [7:0]        c;
        logic              eos;
        logic [2:0]        n;
        logic [0:3][10:0]  r;
    } row_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_char_in;
    logic       s_end_of_script;
    logic       m_valid;
    logic       m_ready;
    logic [2:0] m_kind;
    logic [7:0] m_char_out;
    logic       m_run_last;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [3:0] cfg_index;
    logic [7:0] cfg_data;

    lex_state_t lx;
    lex_cfg_t   lcfg;
    tok_t       lex_out[$];
    tok_t       tokens_due[$];
    row_t       bytes_offered[$];
    row_t       dir_rows [27];

    int  errors;
    int  idle_cycles;
    int  bytes_sent;
    int  scripts_sent;
    int  tokens_checked;
    int  cfg_writes;
    int  directed_bytes;
    bit  s_quiet;
    bit  m_quiet;
    bit  hold_off_req;

    always #1 aclk = ~aclk;

    script_word_tokenizer_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_in       (s_char_in),
        .s_end_of_script (s_end_of_script),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_char_out      (m_char_out),
        .m_run_last      (m_run_last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // ---------------- token predictor ----------------

    function automatic void add_tok(input logic [2:0] kind, input logic [7:0] ch);
        tok_t t;
        t.kind = kind;
        t.ch   = (kind == KIND_CHAR) ? ch : 8'h00;
        t.last = 1'b0;
        lex_out.insert(lex_out.size(), t);
    endfunction

    function automatic void close_run();
        if (lex_out.size() > 0)
            lex_out[lex_out.size() - 1].last = 1'b1;
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        case (c)
            CH_SEMI, CH_COMMA, CH_EQ, CH_LBRK, CH_RBRK, CH_LT, CH_GT,
            CH_LPAR, CH_RPAR, CH_LBRACE, CH_RBRACE: return 1'b1;
            CH_PLUS, CH_MINUS, CH_STAR: return lcfg.arith_delimiters;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void lex_step(input logic [7:0] c_in, input logic eos);
        logic [7:0] c;
        c = c_in;
        lex_out.delete();
        if (lcfg.map_line_breaks && (c == CH_CR || c == CH_LF))
            c = CH_SPACE;

        if (lx.in_quote) begin
            if (lx.escape_pending) begin
                lx.escape_pending = 1'b0;
                if (c == CH_BSLASH || c == CH_QUOTE) begin
                    add_tok(KIND_CHAR, c);
                end else begin
                    // keep the backslash when it escapes nothing
                    add_tok(KIND_CHAR, CH_BSLASH);
                    add_tok(KIND_CHAR, c);
                end
            end else if (c == CH_BSLASH) begin
                lx.escape_pending = 1'b1;
            end else if (c == CH_QUOTE) begin
                add_tok(KIND_END, 8'h00);
                lx.in_quote = 1'b0;
            end else begin
                add_tok(KIND_CHAR, c);
            end
        end else if (c == CH_SPACE) begin
            if (lx.word_open)
                add_tok(KIND_END, 8'h00);
            lx.word_open = 1'b0;
        end else if (c == CH_QUOTE) begin
            if (lx.word_open)
                add_tok(KIND_DROP, 8'h00);
            lx.word_open      = 1'b0;
            lx.in_quote       = 1'b1;
            lx.escape_pending = 1'b0;
        end else if (is_delim(c)) begin
            if (lx.word_open)
                add_tok(KIND_END, 8'h00);
            lx.word_open = 1'b0;
            add_tok(KIND_CHAR, c);
            add_tok(KIND_END, 8'h00);
        end else begin
            add_tok(KIND_CHAR, c);
            lx.word_open = 1'b1;
        end

        if (eos) begin
            if (lx.in_quote) begin
                add_tok(KIND_ERR, 8'h00);
            end else begin
                if (lx.word_open)
                    add_tok(KIND_END, 8'h00);
                add_tok(KIND_OK, 8'h00);
            end
            lx = '0;
        end
        close_run();
    endfunction

    // ---------------- monitors and watchdog ----------------

    always @(posedge aclk) begin
        row_t acc;
        tok_t want;
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;

        if (aresetn && s_valid && s_ready) begin
            acc = bytes_offered.pop_front();
            lex_step(acc.c, acc.eos);
            if (acc.n != N_PRED) begin
                lex_out.delete();
                for (int k = 0; k < int'(acc.n); k++)
                    add_tok(acc.r[k][10:8], acc.r[k][7:0]);
                close_run();
            end
            foreach (lex_out[k])
                tokens_due.insert(tokens_due.size(), lex_out[k]);
        end

        if (aresetn && m_valid && m_ready) begin
            if (tokens_due.size() == 0) begin
                $error("unexpected result: kind %0d char_out 8'h%02h run_last %0d",
                       m_kind, m_char_out, m_run_last);
                errors++;
            end else begin
                want = tokens_due.pop_front();
                tokens_checked++;
                if (m_kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, m_kind);
                    errors++;
                end
                if (m_char_out !== want.ch) begin
                    $error("char_out: expected 8'h%02h, got 8'h%02h", want.ch, m_char_out);
                    errors++;
                end
                if (m_run_last !== want.last) begin
                    $error("run_last: expected %0d, got %0d", want.last, m_run_last);
                    errors++;
                end
            end
        end

        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
            $display("** script_word_tokenizer_top: FAILED **");
            $finish;
        end
    end

    // ---------------- result consumer ----------------

    function automatic int m_gap();
        int r;
        r = $urandom_range(0, 99);
        if (m_quiet || r < 75)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                // hold off long enough for the block to back up into its input
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            stall = m_gap();
            if (stall == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // ---------------- byte source ----------------

    function automatic int s_gap();
        int r;
        r = $urandom_range(0, 99);
        if (s_quiet || r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    function automatic row_t pred_row(input logic [7:0] c, input logic eos);
        row_t rw;
        rw     = '0;
        rw.c   = c;
        rw.eos = eos;
        rw.n   = N_PRED;
        return rw;
    endfunction

    function automatic logic [7:0] pick_letter();
        if ($urandom_range(0, 99) < 85)
            return 8'($urandom_range(8'h61, 8'h7A));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0, 1:    return CH_SPACE;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] pick_punct();
        case ($urandom_range(0, 13))
            0:       return CH_SEMI;
            1:       return CH_COMMA;
            2:       return CH_EQ;
            3:       return CH_LBRK;
            4:       return CH_RBRK;
            5:       return CH_LT;
            6:       return CH_GT;
            7:       return CH_LPAR;
            8:       return CH_RPAR;
            9:       return CH_LBRACE;
            10:      return CH_RBRACE;
            11:      return CH_PLUS;
            12:      return CH_MINUS;
            default: return CH_STAR;
        endcase
    endfunction

    function automatic logic [7:0] pick_last();
        case ($urandom_range(0, 5))
            0:       return pick_letter();
            1:       return CH_QUOTE;
            2:       return CH_BSLASH;
            3:       return pick_blank();
            4:       return pick_punct();
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // enter at a falling edge, leave at the falling edge after the word is taken
    task automatic send_byte(input row_t rw);
        int gap;
        gap = s_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        bytes_offered.insert(bytes_offered.size(), rw);
        s_valid         <= 1'b1;
        s_char_in       <= rw.c;
        s_end_of_script <= rw.eos;
        do @(posedge aclk); while (s_ready !== 1'b1);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_quoted();
        int len;
        int r;
        send_byte(pred_row(CH_QUOTE, 1'b0));
        len = $urandom_range(0, 4);
        repeat (len) begin
            r = $urandom_range(0, 9);
            if (r < 6) begin
                send_byte(pred_row(pick_letter(), 1'b0));
            end else if (r < 8) begin
                send_byte(pred_row(CH_BSLASH, 1'b0));
                send_byte(pred_row(r[0] ? CH_QUOTE : CH_BSLASH, 1'b0));
            end else begin
                send_byte(pred_row(CH_BSLASH, 1'b0));
                send_byte(pred_row(pick_last(), 1'b0));
            end
        end
        // leave the odd quote open
        if ($urandom_range(0, 9) != 0)
            send_byte(pred_row(CH_QUOTE, 1'b0));
    endtask

    task automatic send_script();
        int n_tok;
        int pick;
        int len;
        n_tok = $urandom_range(1, 6);
        repeat (n_tok) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                len = $urandom_range(1, 4);
                repeat (len) send_byte(pred_row(pick_letter(), 1'b0));
            end else if (pick < 50) begin
                send_byte(pred_row(pick_blank(), 1'b0));
            end else if (pick < 65) begin
                send_byte(pred_row(pick_punct(), 1'b0));
            end else if (pick < 90) begin
                send_quoted();
            end else begin
                send_byte(pred_row(8'($urandom_range(0, 255)), 1'b0));
            end
        end
        send_byte(pred_row(pick_last(), 1'b1));
        scripts_sent++;
    endtask

    task automatic run_scripts(input int n_bytes);
        int target;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target)
            send_script();
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (bytes_offered.size() != 0 || tokens_due.size() != 0)
            @(negedge aclk);
        // a byte with no result may still be in flight
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [3:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        if (idx == REG_MAP_LINE_BREAKS)
            lcfg.map_line_breaks = data[0];
        else if (idx == REG_ARITH_DELIMITERS)
            lcfg.arith_delimiters = data[0];
        cfg_writes++;
        @(negedge aclk);
    endtask

    task automatic reconfigure(input logic [7:0] map_d, input logic [7:0] arith_d,
                               input logic [3:0] spare_idx, input logic [7:0] spare_d);
        wait_drained();
        cfg_write(REG_MAP_LINE_BREAKS, map_d);
        cfg_write(REG_ARITH_DELIMITERS, arith_d);
        cfg_write(spare_idx, spare_d);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_char_in       = 8'h00;
        s_end_of_script = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = 4'd0;
        cfg_data        = 8'h00;
        s_quiet         = 1'b0;
        m_quiet         = 1'b0;
        hold_off_req    = 1'b0;
        errors          = 0;
        idle_cycles     = 0;
        bytes_sent      = 0;
        scripts_sent    = 0;
        tokens_checked  = 0;
        cfg_writes      = 0;
        lx              = '0;
        lcfg.map_line_breaks  = 1'b1;
        lcfg.arith_delimiters = 1'b0;

        // reset settings: CR/LF map to space, + - * are word characters
        dir_rows = '{
            '{"a",       1'b0, 3'd1,   {{KIND_CHAR, "a"}, NIL, NIL, NIL}},
            '{8'hFF,     1'b0, 3'd1,   {{KIND_CHAR, 8'hFF}, NIL, NIL, NIL}},
            '{8'h00,     1'b0, 3'd1,   {{KIND_CHAR, 8'h00}, NIL, NIL, NIL}},
            '{CH_SPACE,  1'b0, 3'd1,   {R_END, NIL, NIL, NIL}},
            '{CH_SEMI,   1'b0, 3'd2,   {{KIND_CHAR, CH_SEMI}, R_END, NIL, NIL}},
            '{"x",       1'b0, N_PRED, {4{NIL}}},
            '{CH_QUOTE,  1'b0, 3'd1,   {R_DROP, NIL, NIL, NIL}},
            '{CH_BSLASH, 1'b0, 3'd0,   {4{NIL}}},
            '{"n",       1'b0, N_PRED, {4{NIL}}},
            '{CH_BSLASH, 1'b0, N_PRED, {4{NIL}}},
            '{CH_QUOTE,  1'b0, 3'd1,   {{KIND_CHAR, CH_QUOTE}, NIL, NIL, NIL}},
            '{CH_BSLASH, 1'b0, N_PRED, {4{NIL}}},
            '{CH_BSLASH, 1'b0, N_PRED, {4{NIL}}},
            '{CH_QUOTE,  1'b0, 3'd1,   {R_END, NIL, NIL, NIL}},
            '{"b",       1'b0, N_PRED, {4{NIL}}},
            '{CH_CR,     1'b0, N_PRED, {4{NIL}}},
            '{CH_PLUS,   1'b0, N_PRED, {4{NIL}}},
            '{"c",       1'b1, N_PRED, {4{NIL}}},
            '{CH_QUOTE,  1'b0, N_PRED, {4{NIL}}},
            '{"z",       1'b1, 3'd2,   {{KIND_CHAR, "z"}, R_ERR, NIL, NIL}},
            '{CH_QUOTE,  1'b0, N_PRED, {4{NIL}}},
            '{CH_BSLASH, 1'b1, 3'd1,   {R_ERR, NIL, NIL, NIL}},
            '{"w",       1'b0, N_PRED, {4{NIL}}},
            '{CH_SEMI,   1'b1, 3'd4,   {R_END, {KIND_CHAR, CH_SEMI}, R_END, R_OK}},
            '{CH_SPACE,  1'b1, 3'd1,   {R_OK, NIL, NIL, NIL}},
            '{CH_QUOTE,  1'b0, N_PRED, {4{NIL}}},
            '{CH_QUOTE,  1'b1, 3'd2,   {R_END, R_OK, NIL, NIL}}
        };

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            send_byte(dir_rows[i]);
        directed_bytes = bytes_sent;

        // raw line breaks, arithmetic delimiters; masked data, ignored index
        reconfigure(8'hFE, 8'h01, 4'd15, 8'hFF);
        run_scripts(75);

        // back up the output while bytes keep coming
        reconfigure(8'hFF, 8'h03, 4'($urandom_range(2, 14)), 8'($urandom_range(0, 255)));
        s_quiet      = 1'b1;
        hold_off_req = 1'b1;
        run_scripts(75);
        s_quiet = 1'b0;

        // full rate on both sides
        reconfigure(8'h00, 8'hAA, 4'($urandom_range(2, 14)), 8'($urandom_range(0, 255)));
        s_quiet = 1'b1;
        m_quiet = 1'b1;
        run_scripts(75);
        s_quiet = 1'b0;
        m_quiet = 1'b0;

        reconfigure(8'h01, 8'h54, 4'($urandom_range(2, 14)), 8'($urandom_range(0, 255)));
        run_scripts(75);

        wait_drained();

        $display("Covered %0d bytes (%0d directed) in %0d random scripts, %0d results checked,",
                 bytes_sent, directed_bytes, scripts_sent, tokens_checked);
        $display("with %0d register writes across five settings and one long output hold-off.",
                 cfg_writes);
        if (errors == 0) begin
            $display("** script_word_tokenizer_top: PASSED **");
        end else begin
            $display("** script_word_tokenizer_top: FAILED **");
        end
        $finish;
    end

endmodule
